/* design/bfh_pkg.sv */
// ----------------------------------------------------------------------------
// Back/forward history package
// Shared item kind codes and the control and status bundles of a history stack.
// ----------------------------------------------------------------------------
package bfh_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_VISIT   = 2'd0;
   localparam kind_type KIND_BACK    = 2'd1;
   localparam kind_type KIND_FORWARD = 2'd2;
   localparam kind_type KIND_CLEAR   = 2'd3;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stack_cmd_type;

   typedef struct packed {
      logic nonempty;
      logic nonempty_next;
   } stack_status_type;

endpackage

/* design/bfh_if.sv */
// ----------------------------------------------------------------------------
// Back/forward history channels
// Valid/ready channels for the request items and the response items.
// ----------------------------------------------------------------------------
interface bfh_req_if #(
   parameter int TOKEN_WIDTH = 32
);
   import bfh_pkg::*;

   logic                   valid;
   logic                   ready;
   kind_type               kind;
   logic [TOKEN_WIDTH-1:0] location;

   modport source (output valid, output kind, output location, input ready);
   modport sink   (input valid, input kind, input location, output ready);
endinterface

interface bfh_rsp_if #(
   parameter int TOKEN_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [TOKEN_WIDTH-1:0] target;
   logic                   can_go_back;
   logic                   can_go_forward;

   modport source (output valid, output ok, output target, output can_go_back,
                   output can_go_forward, input ready);
   modport sink   (input valid, input ok, input target, input can_go_back,
                   input can_go_forward, output ready);
endinterface

/* design/back_forward_history_stacks.sv */
// A request passes through the input register, then the response register.
// Throughput: one item per cycle while the response side is ready, set by
// the single ring pointer update of each stack per cycle.
// Reset clears both fill counts, the pointers and the valid flags; stack
// entries are not cleared, and a pop may load an unwritten entry as second.
// ----------------------------------------------------------------------------
// Back/forward history stacks
// Two bounded stacks of location tokens serving visit, back, forward and
// clear items, one response per item.
// ----------------------------------------------------------------------------
module back_forward_history_stacks #(
   parameter int HISTORY_DEPTH = 16,
   parameter int TOKEN_WIDTH   = 32
) (
   input  logic     clock,
   input  logic     reset,
   bfh_req_if.sink  req,
   bfh_rsp_if.source rsp
);
   import bfh_pkg::*;

   logic                   in_valid_ff;
   kind_type               in_kind_ff;
   logic [TOKEN_WIDTH-1:0] in_location_ff;
   logic                   advance;

   logic                   out_valid_ff;
   logic                   out_ok_ff, out_ok_in;
   logic [TOKEN_WIDTH-1:0] out_target_ff, out_target_in;
   logic                   out_back_ff, out_back_in;
   logic                   out_forward_ff, out_forward_in;

   stack_cmd_type          back_cmd, forward_cmd;
   stack_status_type       back_status, forward_status;
   logic [TOKEN_WIDTH-1:0] back_top, forward_top;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_kind_ff     <= req.kind;
         in_location_ff <= req.location;
      end
   end

   always_comb begin
      back_cmd      = '0;
      forward_cmd   = '0;
      out_ok_in     = 1'b0;
      out_target_in = '0;
      unique case (in_kind_ff)
         KIND_VISIT: begin
            back_cmd.push     = advance;
            forward_cmd.clear = advance;
         end
         KIND_BACK: begin
            if (back_status.nonempty) begin
               back_cmd.pop     = advance;
               forward_cmd.push = advance;
               out_ok_in        = 1'b1;
               out_target_in    = back_top;
            end
         end
         KIND_FORWARD: begin
            if (forward_status.nonempty) begin
               forward_cmd.pop = advance;
               back_cmd.push   = advance;
               out_ok_in       = 1'b1;
               out_target_in   = forward_top;
            end
         end
         KIND_CLEAR: begin
            back_cmd.clear    = advance;
            forward_cmd.clear = advance;
         end
         default: begin
            back_cmd = '0;
         end
      endcase
      out_back_in    = back_status.nonempty_next;
      out_forward_in = forward_status.nonempty_next;
   end

   bfh_stack #(
      .DEPTH (HISTORY_DEPTH),
      .WIDTH (TOKEN_WIDTH)
   ) u_back_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .push_data (in_location_ff),
      .top_data  (back_top),
      .status    (back_status)
   );

   bfh_stack #(
      .DEPTH (HISTORY_DEPTH),
      .WIDTH (TOKEN_WIDTH)
   ) u_forward_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (forward_cmd),
      .push_data (in_location_ff),
      .top_data  (forward_top),
      .status    (forward_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ok_ff      <= out_ok_in;
         out_target_ff  <= out_target_in;
         out_back_ff    <= out_back_in;
         out_forward_ff <= out_forward_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.ok             = out_ok_ff;
   assign rsp.target         = out_target_ff;
   assign rsp.can_go_back    = out_back_ff;
   assign rsp.can_go_forward = out_forward_ff;

   // A successful move always leaves the other history nonempty.
   a_ok_leaves_history: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ok |-> rsp.can_go_back || rsp.can_go_forward)
      else $error("Successful move reported with both histories empty.");

   a_fail_zero_target: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ok |-> rsp.target == '0)
      else $error("Failed or non-move item reported a nonzero target.");

   a_single_stack_op: assert property (@(posedge clock) disable iff (reset)
      !(back_cmd.push && back_cmd.pop) && !(forward_cmd.push && forward_cmd.pop))
      else $error("A stack was asked to push and pop in the same cycle.");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("Response valid right after reset.");

endmodule

/* design/bfh_stack.sv */
// ----------------------------------------------------------------------------
// Bounded history stack
// Ring buffer with a head pointer and a fill count. The top and the entry
// below it are held in registers so that a pop takes its new top from a register.
// ----------------------------------------------------------------------------
module bfh_stack #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bfh_pkg::stack_cmd_type    cmd,
   input  logic [WIDTH-1:0]          push_data,
   output logic [WIDTH-1:0]          top_data,
   output bfh_pkg::stack_status_type status
);
   import bfh_pkg::*;

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   logic [WIDTH-1:0]  entries_ff [DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [WIDTH-1:0]  top_ff, second_ff;
   logic [PTR_W-1:0]  refill_addr;

   // After a pop the new second entry sits three places below the old head.
   assign refill_addr = ptr_dec(ptr_dec(ptr_dec(head_ff)));

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.push) begin
         head_in = ptr_inc(head_ff);
         if (fill_ff != FILL_W'(DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end else if (cmd.pop) begin
         head_in = ptr_dec(head_ff);
         fill_in = fill_ff - 1'b1;
      end
      if (cmd.clear) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         entries_ff[head_ff] <= push_data;
         top_ff              <= push_data;
         second_ff           <= top_ff;
      end else if (cmd.pop) begin
         top_ff    <= second_ff;
         second_ff <= entries_ff[refill_addr];
      end
   end

   assign top_data             = top_ff;
   assign status.nonempty      = (fill_ff != '0);
   assign status.nonempty_next = (fill_in != '0);

endmodule
